// File: hw/rtl/icf_pkg.sv
package icf_pkg;

	// Factorial of any operand above this is zero modulo 2^64 and below.
	localparam int FACT_CAP = 80;

	localparam int PC_W = 4;

	typedef logic [3:0]      op_t;
	typedef logic [2:0]      cond_t;
	typedef logic [PC_W-1:0] pc_t;

	// Datapath operations
	localparam op_t OP_NOP       = 4'd0;
	localparam op_t OP_LOAD      = 4'd1;
	localparam op_t OP_MUL_INIT  = 4'd2;
	localparam op_t OP_MUL_STEP  = 4'd3;
	localparam op_t OP_DIV_INIT  = 4'd4;
	localparam op_t OP_DIV_STEP  = 4'd5;
	localparam op_t OP_DIV_FIX   = 4'd6;
	localparam op_t OP_FACT_A    = 4'd7;
	localparam op_t OP_FACT_STEP = 4'd8;
	localparam op_t OP_FACT_B    = 4'd9;
	localparam op_t OP_EMIT      = 4'd10;

	// Jump conditions
	localparam cond_t C_NEVER     = 3'd0;
	localparam cond_t C_ALWAYS    = 3'd1;
	localparam cond_t C_NO_INPUT  = 3'd2;
	localparam cond_t C_LOOP      = 3'd3;
	localparam cond_t C_FACT_LIVE = 3'd4;
	localparam cond_t C_OUT_BUSY  = 3'd5;

	// Program step addresses
	localparam pc_t PC_WAIT   = 4'd0;
	localparam pc_t PC_MUL    = 4'd2;
	localparam pc_t PC_DIV    = 4'd4;
	localparam pc_t PC_FACT_A = 4'd7;
	localparam pc_t PC_FACT_B = 4'd9;
	localparam pc_t PC_EMIT   = 4'd10;
	localparam pc_t PC_LAST   = 4'd11;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ucode_t;

	typedef struct packed {
		logic in_valid;
		logic out_busy;
		logic loop_more;
		logic fact_done;
	} flags_t;

	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t w;
		case (pc)
			4'd0:    w = '{OP_LOAD,      C_NO_INPUT,  PC_WAIT};
			4'd1:    w = '{OP_MUL_INIT,  C_NEVER,     PC_WAIT};
			4'd2:    w = '{OP_MUL_STEP,  C_LOOP,      PC_MUL};
			4'd3:    w = '{OP_DIV_INIT,  C_NEVER,     PC_WAIT};
			4'd4:    w = '{OP_DIV_STEP,  C_LOOP,      PC_DIV};
			4'd5:    w = '{OP_DIV_FIX,   C_NEVER,     PC_WAIT};
			4'd6:    w = '{OP_FACT_A,    C_NEVER,     PC_WAIT};
			4'd7:    w = '{OP_FACT_STEP, C_FACT_LIVE, PC_FACT_A};
			4'd8:    w = '{OP_FACT_B,    C_NEVER,     PC_WAIT};
			4'd9:    w = '{OP_FACT_STEP, C_FACT_LIVE, PC_FACT_B};
			4'd10:   w = '{OP_EMIT,      C_OUT_BUSY,  PC_EMIT};
			4'd11:   w = '{OP_NOP,       C_ALWAYS,    PC_WAIT};
			default: w = '{OP_NOP,       C_ALWAYS,    PC_WAIT};
		endcase
		return w;
	endfunction

endpackage

// File: hw/rtl/icf_seq.sv
module icf_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  icf_pkg::flags_t  flags,
	output icf_pkg::ucode_t  ucode
);
	import icf_pkg::*;

	pc_t  pc_q;
	logic take;

	assign ucode = ucode_rom(pc_q);

	always_comb begin
		case (ucode.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_INPUT:  take = !flags.in_valid;
			C_LOOP:      take = flags.loop_more;
			C_FACT_LIVE: take = !flags.fact_done;
			C_OUT_BUSY:  take = flags.out_busy;
			default:     take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else if (take) begin
			pc_q <= ucode.target;
		end else begin
			pc_q <= pc_q + pc_t'(1);
		end
	end

endmodule

// File: hw/rtl/integer_calc_with_factorial.sv
// Integer calculator: each input item carries two signed operands (a in the low
// half of s_tdata, b above it) and yields one result item with a+b, a-b, a/b
// truncated toward zero, the low bits of a*b, and a! and b! modulo
// 2^DATA_WIDTH. Flags in m_tuser mark a zero divisor (quotient then reads 0)
// and a negative operand (its factorial then reads 1). A small microcode
// program steps a shared datapath: a bit-serial shift-add multiply and a
// restoring divide of DATA_WIDTH steps each, then one narrow multiply per
// factorial term. The factorial multiplications done per operand are n-1
// for n of 2 or more, stopping once the running product wraps to zero, and
// none above 80. Items are taken one at a time; the next item is accepted
// while the previous result still waits in the output register.
module integer_calc_with_factorial #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// operand_a, operand_b
	input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// sum, difference, quotient, product, factorial_a, factorial_b
	output logic [((6*DATA_WIDTH+7)/8)*8-1:0]      m_tdata,
	// divide_by_zero, a_negative, b_negative
	output logic [2:0]                             m_tuser
);
	import icf_pkg::*;

	localparam int DW    = DATA_WIDTH;
	localparam int OUT_W = ((6*DATA_WIDTH+7)/8)*8;
	localparam int MAXN  = (DATA_WIDTH > FACT_CAP) ? DATA_WIDTH : FACT_CAP;
	localparam int CNT_W = $clog2(MAXN + 2);
	localparam int CMP_W = (DATA_WIDTH > CNT_W) ? DATA_WIDTH : CNT_W;

	ucode_t ucode;
	flags_t flags;

	// Operands and working registers
	logic [DW-1:0]    a_q, b_q;
	logic [DW-1:0]    prod_q;      // product accumulator
	logic [DW-1:0]    rem_q;       // multiplicand, then division remainder
	logic [DW-1:0]    sh_q;        // multiplier, then dividend/quotient shifter
	logic [DW-1:0]    dvs_q;       // divisor magnitude
	logic [DW-1:0]    quo_q;
	logic [DW-1:0]    n_q;         // factorial argument
	logic [DW-1:0]    acc_q;       // factorial running product
	logic [DW-1:0]    fa_q;
	logic [CNT_W-1:0] cnt_q;       // step count, or factorial term

	// Output register
	logic [OUT_W-1:0] m_tdata_q;
	logic [2:0]       m_tuser_q;
	logic             m_tvalid_q;

	logic             s_fire, emit_fire, out_busy;
	logic [DW:0]      div_t, div_d;
	logic             div_ge;
	logic [DW+CNT_W-1:0] fact_mul;
	logic             fact_done;
	logic [DW-1:0]    mag_a, mag_b;
	logic             a_zero_init, b_zero_init;

	assign out_busy  = m_tvalid_q && !m_tready;
	assign s_tready  = (ucode.op == OP_LOAD);
	assign s_fire    = s_tvalid && s_tready;
	assign emit_fire = (ucode.op == OP_EMIT) && !out_busy;

	assign mag_a = a_q[DW-1] ? (~a_q + DW'(1)) : a_q;
	assign mag_b = b_q[DW-1] ? (~b_q + DW'(1)) : b_q;

	// Restoring divide: shift in the next dividend bit, subtract if it fits.
	assign div_t  = {rem_q, sh_q[DW-1]};
	assign div_d  = div_t - {1'b0, dvs_q};
	assign div_ge = !div_d[DW];

	assign fact_mul  = acc_q * cnt_q;
	assign fact_done = n_q[DW-1] || (acc_q == '0) || (CMP_W'(cnt_q) > CMP_W'(n_q));

	// Above the cap the factorial is already zero, so start from zero.
	assign a_zero_init = !a_q[DW-1] && (CMP_W'(a_q) > CMP_W'(FACT_CAP));
	assign b_zero_init = !b_q[DW-1] && (CMP_W'(b_q) > CMP_W'(FACT_CAP));

	assign flags.in_valid  = s_tvalid;
	assign flags.out_busy  = out_busy;
	assign flags.loop_more = (cnt_q != CNT_W'(1));
	assign flags.fact_done = fact_done;

	icf_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ucode  (ucode)
	);

	// Datapath: each control word picks one operation.
	always_ff @(posedge clk) begin
		case (ucode.op)
			OP_LOAD: begin
				if (s_fire) begin
					a_q <= s_tdata[DW-1:0];
					b_q <= s_tdata[2*DW-1:DW];
				end
			end
			OP_MUL_INIT: begin
				prod_q <= '0;
				rem_q  <= a_q;
				sh_q   <= b_q;
				cnt_q  <= CNT_W'(DW);
			end
			OP_MUL_STEP: begin
				// add the shifted multiplicand where the multiplier bit is set
				prod_q <= prod_q + (sh_q[0] ? rem_q : '0);
				rem_q  <= {rem_q[DW-2:0], 1'b0};
				sh_q   <= {1'b0, sh_q[DW-1:1]};
				cnt_q  <= cnt_q - CNT_W'(1);
			end
			OP_DIV_INIT: begin
				rem_q <= '0;
				sh_q  <= mag_a;
				dvs_q <= mag_b;
				cnt_q <= CNT_W'(DW);
			end
			OP_DIV_STEP: begin
				rem_q <= div_ge ? div_d[DW-1:0] : div_t[DW-1:0];
				sh_q  <= {sh_q[DW-2:0], div_ge};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			OP_DIV_FIX: begin
				// apply the sign; a zero divisor forces zero
				if (b_q == '0) begin
					quo_q <= '0;
				end else if (a_q[DW-1] != b_q[DW-1]) begin
					quo_q <= ~sh_q + DW'(1);
				end else begin
					quo_q <= sh_q;
				end
			end
			OP_FACT_A: begin
				n_q   <= a_q;
				acc_q <= a_zero_init ? '0 : DW'(1);
				cnt_q <= CNT_W'(2);
			end
			OP_FACT_STEP: begin
				if (!fact_done) begin
					acc_q <= fact_mul[DW-1:0];
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			OP_FACT_B: begin
				fa_q  <= acc_q;
				n_q   <= b_q;
				acc_q <= b_zero_init ? '0 : DW'(1);
				cnt_q <= CNT_W'(2);
			end
			default: begin
			end
		endcase
	end

	// Output payload: load once the result register is free.
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			m_tdata_q <= OUT_W'({acc_q, fa_q, prod_q, quo_q, a_q - b_q, a_q + b_q});
			m_tuser_q <= {b_q[DW-1], a_q[DW-1], (b_q == '0)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// An accepted item always starts the multiply.
	a_load_then_mul: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> (ucode.op == OP_MUL_INIT))
		else $error("accepted item did not start the program");

	// A result only appears through the emit step.
	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(emit_fire))
		else $error("result valid raised outside emit");

	// A pending result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |=> $stable(m_tdata_q) && m_tvalid_q)
		else $error("pending result changed");

	// A zero divisor always reports a zero quotient.
	a_dz_quotient: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tuser_q[0]) |-> (m_tdata_q[3*DW-1:2*DW] == '0))
		else $error("nonzero quotient with zero divisor");

endmodule
